@@ sv/pspi_pkg.sv @@
// Package: types, constants and codes for the projected slice point interpolator.
package pspi_pkg;

  localparam int MAX_SLICES_DEF = 1024;
  localparam int DIST_W = 48;
  localparam int VAL_W  = 32;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [47:0] distance;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] scale;
    logic signed [31:0] surface_offset;
    logic signed [31:0] depth;
    logic signed [31:0] occlusion_limit;
    logic signed [31:0] lateral;
    logic signed [31:0] elevation;
    logic               relative;
  } in_item_t;

  typedef struct packed {
    logic               ready_res;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] point_depth;
    logic signed [31:0] point_occlusion;
    logic               visible;
  } out_item_t;

  // One stored slice: distance then six Q16.16 values (240 bits)
  typedef struct packed {
    logic signed [47:0] slice_dist;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] sc;
    logic signed [31:0] so;
    logic signed [31:0] dp;
    logic signed [31:0] oc;
  } slice_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_FIRST,
    ST_RD_LAST,
    ST_CHK_RANGE,
    ST_SCAN,
    ST_SCAN_CHK,
    ST_DIV,
    ST_LERP,
    ST_MUL_X,
    ST_MUL_Y,
    ST_FINISH,
    ST_OUT
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

@@ sv/pspi_store.sv @@
// Slice memory: one write port, one registered read port.
module pspi_store #(
  parameter int MAX_SLICES = pspi_pkg::MAX_SLICES_DEF,
  parameter int AW = $clog2(MAX_SLICES)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  pspi_pkg::slice_t   wr_data,
  input  logic [AW-1:0]      rd_addr,
  output pspi_pkg::slice_t   rd_data
);
  import pspi_pkg::*;

  slice_t mem [MAX_SLICES];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

@@ sv/pspi_alu.sv @@
// Shared arithmetic unit: one restoring division step, or one lerp / Q16.16 product.
module pspi_alu (
  input  logic               div_step,
  input  logic [48:0]        rem_in,
  input  logic [48:0]        span,
  input  logic [32:0]        quo_in,
  output logic [48:0]        rem_out,
  output logic [32:0]        quo_out,
  // multiply operands
  input  logic signed [33:0] mul_a,
  input  logic signed [33:0] mul_b,
  output logic signed [67:0] mul_p
);
  logic [49:0] rem_sh;

  // Restoring division step: shift remainder, compare and subtract
  always_comb begin
    rem_sh  = {rem_in, 1'b0};
    rem_out = rem_in;
    quo_out = quo_in;
    if (div_step) begin
      if (rem_sh >= {1'b0, span}) begin
        rem_out = 49'(rem_sh - {1'b0, span});
        quo_out = 33'({quo_in, 1'b1});
      end else begin
        rem_out = rem_sh[48:0];
        quo_out = 33'({quo_in, 1'b0});
      end
    end
  end

  // The one shared multiplier
  assign mul_p = mul_a * mul_b;
endmodule

@@ sv/projected_slice_point_interpolator_unit.sv @@
// Top level: projected slice point interpolator with iterative query sequencer.
// Clear, append and unknown actions are taken while idle and may follow back to back.
// A query reads the end slices, checks the range, scans (ST_SCAN, ST_SCAN_CHK) to the
// bracketing slices N-1 and N, divides (fraction zero for a zero span), then on the shared
// multiplier lerps the six values and forms the screen products; out of range it skips to
// ST_OUT. in_ready stays low meanwhile. Reset (synchronous, active high) empties the table.
module projected_slice_point_interpolator_unit #(
  parameter int MAX_SLICES = pspi_pkg::MAX_SLICES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pspi_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pspi_pkg::out_item_t out_data
);
  import pspi_pkg::*;

  localparam int AW = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
  localparam int CW = $clog2(MAX_SLICES + 1);

  state_t state, state_next;

  in_item_t    req;
  logic [CW-1:0] total;
  logic [CW-1:0] idx;
  slice_t      rd_data, far_s, near_s;
  logic [AW-1:0] rd_addr;
  logic        wr_en;

  logic [48:0] rem, rem_n, span;
  logic [32:0] quo, quo_n;
  logic [5:0]  step;
  logic        div_step;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;
  logic signed [31:0] res [6];
  logic signed [31:0] sx, sy;
  out_item_t   res_item;

  pspi_store #(.MAX_SLICES(MAX_SLICES), .AW(AW)) u_store (
    .clk(clk), .wr_en(wr_en), .wr_addr(total[AW-1:0]),
    .wr_data({in_data.distance, in_data.center_x, in_data.center_y, in_data.scale,
              in_data.surface_offset, in_data.depth, in_data.occlusion_limit}),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  pspi_alu u_alu (
    .div_step(div_step), .rem_in(rem), .span(span), .quo_in(quo),
    .rem_out(rem_n), .quo_out(quo_n),
    .mul_a(mul_a), .mul_b(mul_b), .mul_p(mul_p)
  );

  assign in_ready  = (state == ST_IDLE);
  assign wr_en     = in_valid && in_ready && (in_data.action == ACT_APPEND) &&
                     (32'(total) < 32'(MAX_SLICES));
  assign div_step  = (state == ST_DIV);
  assign out_valid = (state == ST_OUT);
  assign out_data  = res_item;

  // Read address per state
  always_comb begin
    unique case (state)
      ST_RD_FIRST: rd_addr = '0;
      ST_RD_LAST:  rd_addr = AW'(total - 1'b1);
      default:     rd_addr = idx[AW-1:0];
    endcase
  end

  // Multiplier operand selection: step 0..5 lerps in ST_LERP, then the ST_MUL_X and ST_MUL_Y products
  logic signed [32:0] diff;
  logic signed [31:0] fv, tv;
  logic signed [32:0] rel;
  always_comb begin
    case (step[2:0])
      3'd0: begin fv = far_s.cx; tv = near_s.cx; end
      3'd1: begin fv = far_s.cy; tv = near_s.cy; end
      3'd2: begin fv = far_s.sc; tv = near_s.sc; end
      3'd3: begin fv = far_s.so; tv = near_s.so; end
      3'd4: begin fv = far_s.dp; tv = near_s.dp; end
      default: begin fv = far_s.oc; tv = near_s.oc; end
    endcase
    diff = 33'(tv) - 33'(fv);
    rel  = req.relative ? 33'(sat32(66'(req.elevation) - 66'(res[3]))) : 33'(req.elevation);
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_LERP: begin
        mul_a = diff[32] ? 34'(-diff) : 34'(diff);
        mul_b = 34'(quo);
      end
      ST_MUL_X: begin mul_a = 34'(req.lateral); mul_b = 34'(res[2]); end
      ST_MUL_Y: begin mul_a = 34'(rel);         mul_b = 34'(res[2]); end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:
        if (in_valid && in_data.action == ACT_QUERY) state_next = ST_RD_FIRST;
      ST_RD_FIRST: state_next = ST_RD_LAST;
      ST_RD_LAST:  state_next = ST_CHK_RANGE;
      ST_CHK_RANGE:
        if (total < CW'(2) || req.distance > far_s.slice_dist ||
            req.distance < rd_data.slice_dist)
          state_next = ST_OUT;
        else state_next = ST_SCAN;
      ST_SCAN: state_next = ST_SCAN_CHK;
      ST_SCAN_CHK:
        if (req.distance <= far_s.slice_dist && req.distance >= rd_data.slice_dist)
          state_next = ST_DIV;
        else if (idx == total - 1'b1) state_next = ST_OUT;
        else state_next = ST_SCAN;
      ST_DIV:    if (step == 6'd32 || step == 6'd63) state_next = ST_LERP;
      ST_LERP:   if (step == 6'd5) state_next = ST_MUL_X;
      ST_MUL_X:  state_next = ST_MUL_Y;
      ST_MUL_Y:  state_next = ST_FINISH;
      ST_FINISH: state_next = ST_OUT;
      ST_OUT:    if (out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Table count
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (in_valid && in_ready) begin
      if (in_data.action == ACT_CLEAR) total <= '0;
      else if (wr_en) total <= total + 1'b1;
    end
  end

  // Datapath: product rounding, then registers
  logic [63:0] dlt;
  logic [31:0] delta;
  logic signed [67:0] prod_r;
  always_comb begin
    prod_r = mul_p + 68'sd32768;
    dlt    = {1'b0, mul_p[63:1]} + 64'd1073741824;
    delta  = 32'(dlt >> 31);
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: if (in_valid) begin
        req <= in_data;
        idx <= CW'(1);
        res_item <= '0;
      end
      ST_RD_FIRST: ;
      ST_RD_LAST: far_s <= rd_data;
      ST_CHK_RANGE: ;
      ST_SCAN: if (idx != CW'(1)) far_s <= near_s;
      ST_SCAN_CHK: begin
        near_s <= rd_data;
        span <= {far_s.slice_dist[47], far_s.slice_dist} -
                {rd_data.slice_dist[47], rd_data.slice_dist};
        rem  <= {far_s.slice_dist[47], far_s.slice_dist} -
                {req.distance[47], req.distance};
        quo  <= '0;
        step <= (far_s.slice_dist == rd_data.slice_dist) ? 6'd63 : 6'd0;
        idx  <= idx + 1'b1;
      end
      ST_DIV: begin
        if (step == 6'd63) begin
          // zero span: fraction stays zero
          quo  <= '0;
          step <= '0;
        end else if (step == 6'd0) begin
          if (rem >= span) begin quo <= 33'd1; rem <= rem - span; end
          step <= 6'd1;
        end else begin
          rem  <= rem_n;
          quo  <= quo_n;
          step <= (step == 6'd32) ? 6'd0 : step + 1'b1;
        end
      end
      ST_LERP: begin
        res[step[2:0]] <= diff[32] ? 32'(fv - $signed({1'b0, delta}))
                                   : 32'(fv + $signed({1'b0, delta}));
        step <= (step == 6'd5) ? 6'd0 : step + 1'b1;
      end
      ST_MUL_X: sx <= sat32(66'(res[0]) + 66'(prod_r >>> 16));
      ST_MUL_Y: sy <= sat32(66'(res[1]) - 66'(prod_r >>> 16));
      ST_FINISH: begin
        res_item.ready_res       <= 1'b1;
        res_item.screen_x        <= sx;
        res_item.screen_y        <= sy;
        res_item.point_depth     <= res[4];
        res_item.point_occlusion <= res[5];
        res_item.visible         <= (sy <= res[5]);
      end
      ST_OUT: ;
      default: ;
    endcase
  end

  // Checks
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result dropped");
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    32'(total) <= 32'(MAX_SLICES)) else $error("table overflow");
endmodule
